FILE: src/rbd_pkg.sv
// ---------------------------------------------------------------------------
// rbd_pkg: shared definitions for the RGBA5551 box downsampler
// Frame geometry, field widths, register indexes, the queued item format and
// the small constant divider used to locate a pixel inside its block.
// ---------------------------------------------------------------------------
package rbd_pkg;

   localparam int FRAME_W     = 320;
   localparam int FRAME_H     = 240;
   localparam int MAX_IMAGE_W = 64;
   localparam int MAX_SAMPLE  = 8;
   localparam int IMAGE_H_CAP = 64;

   localparam int COL_W   = $clog2(FRAME_W);
   localparam int ROW_W   = $clog2(FRAME_H + 1);
   localparam int IMG_W   = 7;
   localparam int SMP_W   = 4;
   localparam int XOFF_W  = 9;
   localparam int YOFF_W  = 8;
   localparam int IX_W    = $clog2(MAX_IMAGE_W);
   localparam int IY_W    = $clog2(IMAGE_H_CAP);
   localparam int SUB_W   = $clog2(MAX_SAMPLE);
   localparam int REL_W   = 9;
   localparam int SPAN_W  = IMG_W + SMP_W;
   localparam int NUM_W   = $clog2(MAX_SAMPLE * MAX_SAMPLE + 1);
   localparam int PIX_W   = 16;
   localparam int CH_W    = 5;
   localparam int SUM_W   = 11;
   localparam int ACC_W   = 3 * SUM_W;
   localparam int INDEX_W = 12;
   localparam int DVD_W   = 12;
   localparam int DVS_W   = NUM_W + 1;
   localparam int QUO_W   = CH_W;
   localparam int STEP_W  = $clog2(QUO_W);

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_W   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_H   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_W  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_H  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_OFFSET  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_OFFSET  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_SWAP = 3'd6;

   localparam int RECIP_SHIFT = 12;
   localparam int RECIP_W     = 11;
   localparam int PROD_W      = REL_W + RECIP_W;

   typedef logic [RECIP_W-1:0] recip_array_type [0:MAX_SAMPLE];

   // ceil(2^12 / d) for d of 3, 5, 6 and 7; exact quotients for every dividend below 512.
   localparam recip_array_type RECIP = '{
      11'd0, 11'd0, 11'd0, 11'd1366, 11'd0, 11'd820, 11'd683, 11'd586, 11'd0
   };

   typedef struct packed {
      logic [IX_W-1:0]    ix;
      logic               first;
      logic               complete;
      logic [CH_W-1:0]    red;
      logic [CH_W-1:0]    green;
      logic [CH_W-1:0]    blue;
      logic [NUM_W-1:0]   count;
      logic [INDEX_W-1:0] out_index;
      logic               last;
      logic               byte_swap;
   } rbd_item_type;

   function automatic logic [REL_W-1:0] div_small(input logic [REL_W-1:0] x,
                                                  input logic [SMP_W-1:0] d);
      logic [PROD_W-1:0] prod;
      logic [REL_W-1:0]  q;
      prod = PROD_W'(x) * PROD_W'(RECIP[d]);
      case (d)
         4'd2:    q = x >> 1;
         4'd4:    q = x >> 2;
         4'd8:    q = x >> 3;
         4'd3, 4'd5, 4'd6, 4'd7: q = REL_W'(prod >> RECIP_SHIFT);
         default: q = x;
      endcase
      return q;
   endfunction

endpackage

FILE: src/rbd_queue.sv
// ---------------------------------------------------------------------------
// rbd_queue: item queue between the front and the back
// A small first-in first-out buffer of classified pixels with an occupancy
// count so that the front can reserve room for items still in its pipeline.
// ---------------------------------------------------------------------------
module rbd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  rbd_pkg::rbd_item_type wr_item,
   input  logic                  rd_en,
   output rbd_pkg::rbd_item_type rd_item,
   output logic                  empty,
   output logic [rbd_pkg::QCNT_W-1:0] count
);
   import rbd_pkg::*;

   rbd_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_item = slot_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign count   = count_ff;

endmodule

FILE: src/rbd_front.sv
// ---------------------------------------------------------------------------
// rbd_front: pixel intake, window test and block classification
// Holds the registers and the frame position, drops pixels outside the
// window, and finds each pixel's block and place in it over two stages.
// ---------------------------------------------------------------------------
module rbd_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [rbd_pkg::PIX_W-1:0]        req_pixel_in,
   input  logic                             req_frame_start,
   input  logic                             csr_we,
   input  logic [rbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rbd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [rbd_pkg::QCNT_W-1:0]       queue_count,
   output logic                             queue_push,
   output rbd_pkg::rbd_item_type            queue_item
);
   import rbd_pkg::*;

   logic [IMG_W-1:0]  image_w_ff;
   logic [IMG_W-1:0]  image_h_ff;
   logic [SMP_W-1:0]  sample_w_ff;
   logic [SMP_W-1:0]  sample_h_ff;
   logic [XOFF_W-1:0] x_offset_ff;
   logic [YOFF_W-1:0] y_offset_ff;
   logic              byte_swap_ff;

   logic [COL_W-1:0]  src_col_ff;
   logic [COL_W-1:0]  src_col_in;
   logic [ROW_W-1:0]  src_row_ff;
   logic [ROW_W-1:0]  src_row_in;

   logic [COL_W-1:0]  pos_col;
   logic [ROW_W-1:0]  pos_row;
   logic              in_frame;
   logic              accept;
   logic [IMG_W-1:0]  iw;
   logic [IMG_W-1:0]  ih;
   logic [SMP_W-1:0]  sw;
   logic [SMP_W-1:0]  sh;
   logic [COL_W-1:0]  rel_col;
   logic [ROW_W-1:0]  rel_row;
   logic [SPAN_W-1:0] span_w;
   logic [SPAN_W-1:0] span_h;
   logic              in_window;

   logic              a_valid_ff;
   logic              a_valid_in;
   logic [REL_W-1:0]  a_rel_col_ff;
   logic [REL_W-1:0]  a_rel_row_ff;
   logic [IMG_W-1:0]  a_iw_ff;
   logic [IMG_W-1:0]  a_ih_ff;
   logic [SMP_W-1:0]  a_sw_ff;
   logic [SMP_W-1:0]  a_sh_ff;
   logic [PIX_W-1:0]  a_pixel_ff;
   logic              a_swap_ff;

   logic              b_valid_ff;
   logic [REL_W-1:0]  b_rel_col_ff;
   logic [REL_W-1:0]  b_rel_row_ff;
   logic [IX_W-1:0]   b_qx_ff;
   logic [IY_W-1:0]   b_qy_ff;
   logic [IMG_W-1:0]  b_iw_ff;
   logic [IMG_W-1:0]  b_ih_ff;
   logic [SMP_W-1:0]  b_sw_ff;
   logic [SMP_W-1:0]  b_sh_ff;
   logic [NUM_W-1:0]  b_count_ff;
   logic [PIX_W-1:0]  b_pixel_ff;
   logic              b_swap_ff;

   logic [SUB_W-1:0]  sx;
   logic [SUB_W-1:0]  sy;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_w_ff   <= IMG_W'(40);
         image_h_ff   <= IMG_W'(40);
         sample_w_ff  <= SMP_W'(2);
         sample_h_ff  <= SMP_W'(2);
         x_offset_ff  <= XOFF_W'(120);
         y_offset_ff  <= YOFF_W'(80);
         byte_swap_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_W:   image_w_ff   <= csr_wdata[IMG_W-1:0];
            CSR_IMAGE_H:   image_h_ff   <= csr_wdata[IMG_W-1:0];
            CSR_SAMPLE_W:  sample_w_ff  <= csr_wdata[SMP_W-1:0];
            CSR_SAMPLE_H:  sample_h_ff  <= csr_wdata[SMP_W-1:0];
            CSR_X_OFFSET:  x_offset_ff  <= csr_wdata[XOFF_W-1:0];
            CSR_Y_OFFSET:  y_offset_ff  <= csr_wdata[YOFF_W-1:0];
            CSR_BYTE_SWAP: byte_swap_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Room is reserved for the two items that may still be in the stages.
   assign req_full = (QCNT_W'(queue_count) + QCNT_W'(a_valid_ff) + QCNT_W'(b_valid_ff))
                     >= QCNT_W'(QUEUE_DEPTH);
   assign accept   = req_push && !req_full;

   always_comb begin
      pos_col  = req_frame_start ? '0 : src_col_ff;
      pos_row  = req_frame_start ? '0 : src_row_ff;
      in_frame = (pos_row < ROW_W'(FRAME_H));

      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      if (accept) begin
         if (!in_frame) begin
            src_col_in = pos_col;
            src_row_in = pos_row;
         end else if (pos_col == COL_W'(FRAME_W - 1)) begin
            src_col_in = '0;
            src_row_in = pos_row + ROW_W'(1);
         end else begin
            src_col_in = pos_col + COL_W'(1);
            src_row_in = pos_row;
         end
      end

      iw = (image_w_ff == '0) ? IMG_W'(1) :
           (image_w_ff > IMG_W'(MAX_IMAGE_W)) ? IMG_W'(MAX_IMAGE_W) : image_w_ff;
      ih = (image_h_ff == '0) ? IMG_W'(1) :
           (image_h_ff > IMG_W'(IMAGE_H_CAP)) ? IMG_W'(IMAGE_H_CAP) : image_h_ff;
      sw = (sample_w_ff == '0) ? SMP_W'(1) :
           (sample_w_ff > SMP_W'(MAX_SAMPLE)) ? SMP_W'(MAX_SAMPLE) : sample_w_ff;
      sh = (sample_h_ff == '0) ? SMP_W'(1) :
           (sample_h_ff > SMP_W'(MAX_SAMPLE)) ? SMP_W'(MAX_SAMPLE) : sample_h_ff;

      rel_col   = pos_col - COL_W'(x_offset_ff);
      rel_row   = pos_row - ROW_W'(y_offset_ff);
      span_w    = SPAN_W'(iw) * SPAN_W'(sw);
      span_h    = SPAN_W'(ih) * SPAN_W'(sh);
      in_window = (COL_W'(x_offset_ff) <= pos_col) && (ROW_W'(y_offset_ff) <= pos_row)
                  && (SPAN_W'(rel_col) < span_w) && (SPAN_W'(rel_row) < span_h);

      a_valid_in = accept && in_frame && in_window;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_rel_col_ff <= REL_W'(rel_col);
      a_rel_row_ff <= REL_W'(rel_row);
      a_iw_ff      <= iw;
      a_ih_ff      <= ih;
      a_sw_ff      <= sw;
      a_sh_ff      <= sh;
      a_pixel_ff   <= req_pixel_in;
      a_swap_ff    <= byte_swap_ff;

      b_rel_col_ff <= a_rel_col_ff;
      b_rel_row_ff <= a_rel_row_ff;
      b_qx_ff      <= IX_W'(div_small(a_rel_col_ff, a_sw_ff));
      b_qy_ff      <= IY_W'(div_small(a_rel_row_ff, a_sh_ff));
      b_iw_ff      <= a_iw_ff;
      b_ih_ff      <= a_ih_ff;
      b_sw_ff      <= a_sw_ff;
      b_sh_ff      <= a_sh_ff;
      b_count_ff   <= NUM_W'(NUM_W'(a_sw_ff) * NUM_W'(a_sh_ff));
      b_pixel_ff   <= a_pixel_ff;
      b_swap_ff    <= a_swap_ff;
   end

   always_comb begin
      sx = SUB_W'(b_rel_col_ff - REL_W'(REL_W'(b_qx_ff) * REL_W'(b_sw_ff)));
      sy = SUB_W'(b_rel_row_ff - REL_W'(REL_W'(b_qy_ff) * REL_W'(b_sh_ff)));

      queue_item.ix        = b_qx_ff;
      queue_item.first     = (sx == '0) && (sy == '0);
      queue_item.complete  = (SMP_W'(sx) == b_sw_ff - SMP_W'(1))
                             && (SMP_W'(sy) == b_sh_ff - SMP_W'(1));
      queue_item.red       = b_pixel_ff[15:11];
      queue_item.green     = b_pixel_ff[10:6];
      queue_item.blue      = b_pixel_ff[5:1];
      queue_item.count     = b_count_ff;
      queue_item.out_index = INDEX_W'(INDEX_W'(b_qy_ff) * INDEX_W'(b_iw_ff))
                             + INDEX_W'(b_qx_ff);
      queue_item.last      = (IMG_W'(b_qx_ff) == b_iw_ff - IMG_W'(1))
                             && (IMG_W'(b_qy_ff) == b_ih_ff - IMG_W'(1));
      queue_item.byte_swap = b_swap_ff;
   end

   assign queue_push = b_valid_ff;

endmodule

FILE: src/rbd_back.sv
// ---------------------------------------------------------------------------
// rbd_back: accumulation, rounded mean and result register
// Adds each queued pixel into its column's sum line and, on the pixel that
// closes a block, divides the three sums bit by bit and packs the result.
// ---------------------------------------------------------------------------
module rbd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  rbd_pkg::rbd_item_type         queue_item,
   input  logic                          queue_empty,
   output logic                          queue_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [rbd_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic [rbd_pkg::INDEX_W-1:0]   rsp_out_index,
   output logic                          rsp_last
);
   import rbd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_OUT
   } back_state_type;

   back_state_type     state_ff;
   rbd_item_type       item_ff;
   logic [ACC_W-1:0]   sums_mem [MAX_IMAGE_W];
   logic [ACC_W-1:0]   rdata_ff;
   logic [DVD_W-1:0]   rem_ff [3];
   logic [DVD_W-1:0]   rem_in [3];
   logic [QUO_W-1:0]   quo_ff [3];
   logic [QUO_W-1:0]   quo_in [3];
   logic [DVS_W-1:0]   divisor_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [PIX_W-1:0]   out_pixel_ff;
   logic [INDEX_W-1:0] out_index_ff;
   logic               out_last_ff;

   logic [ACC_W-1:0]   acc;
   logic [SUM_W-1:0]   sum [3];
   logic [CH_W-1:0]    chan [3];
   logic [DVD_W-1:0]   trial;
   logic               mem_we;
   logic [PIX_W-1:0]   color;

   always_comb begin
      acc     = item_ff.first ? '0 : rdata_ff;
      chan[0] = item_ff.red;
      chan[1] = item_ff.green;
      chan[2] = item_ff.blue;
      for (int c = 0; c < 3; c++) begin
         sum[c] = SUM_W'(chan[c]) + acc[(2 - c) * SUM_W +: SUM_W];
      end

      trial = DVD_W'(divisor_ff) << step_ff;
      for (int c = 0; c < 3; c++) begin
         rem_in[c] = rem_ff[c];
         quo_in[c] = quo_ff[c];
         if (rem_ff[c] >= trial) begin
            rem_in[c]          = rem_ff[c] - trial;
            quo_in[c][step_ff] = 1'b1;
         end
      end

      color = {quo_ff[0], quo_ff[1], quo_ff[2], 1'b1};
      if (item_ff.byte_swap) begin
         color = {color[7:0], color[15:8]};
      end

      out_valid_in = out_valid_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if ((state_ff == ST_OUT) && (!out_valid_ff || rsp_pop)) begin
         out_valid_in = 1'b1;
      end

      queue_pop = (state_ff == ST_IDLE) && !queue_empty;
      mem_we    = (state_ff == ST_ACC);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sums_mem[item_ff.ix] <= {sum[0], sum[1], sum[2]};
      end
      rdata_ff <= sums_mem[queue_item.ix];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (!queue_empty) begin
                  item_ff  <= queue_item;
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               for (int c = 0; c < 3; c++) begin
                  rem_ff[c] <= DVD_W'({sum[c], 1'b0}) + DVD_W'(item_ff.count);
                  quo_ff[c] <= '0;
               end
               divisor_ff <= {item_ff.count, 1'b0};
               step_ff    <= STEP_W'(QUO_W - 1);
               state_ff   <= item_ff.complete ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
               for (int c = 0; c < 3; c++) begin
                  rem_ff[c] <= rem_in[c];
                  quo_ff[c] <= quo_in[c];
               end
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!out_valid_ff || rsp_pop) begin
                  out_pixel_ff <= color;
                  out_index_ff <= item_ff.out_index;
                  out_last_ff  <= item_ff.last;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;
   assign rsp_out_index = out_index_ff;
   assign rsp_last      = out_last_ff;

endmodule

FILE: src/rgb5551_box_downsampler.sv
// ---------------------------------------------------------------------------
// rgb5551_box_downsampler: box-filter downsampler for RGBA5551 pixels
// Averages each sample_w by sample_h block of a window of the frame into one
// RGBA5551 output pixel with its row-major output index.
// ---------------------------------------------------------------------------
// Source pixels are pushed in raster order on the req_ channel; an item is
// taken when req_push is high and req_full is low. Pixels before the window,
// outside it or past the end of the frame are taken at one per cycle while
// req_full is low and produce nothing. Pixels inside the window pass a
// two-stage front and a queue of eight items, then the back's idle and
// accumulate states, where the sum line is read, added to and written. The
// pixel closing a block then passes the divide and output states: the three
// rounded means are found by three bit-per-cycle dividers that share one
// divisor, in five steps. A result waits in an output register until rsp_pop
// is high while rsp_empty is low; the front keeps taking pixels until the
// queue and its stages fill, then raises req_full. Registers are written
// through csr_; the user must do so only while the block is idle, as the
// block does not enforce it. Reset restores the register defaults and frame
// position, empties the queue and the output; the sum line needs no clearing.
// ---------------------------------------------------------------------------
module rgb5551_box_downsampler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [rbd_pkg::PIX_W-1:0]        req_pixel_in,
   input  logic                             req_frame_start,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [rbd_pkg::PIX_W-1:0]        rsp_pixel_out,
   output logic [rbd_pkg::INDEX_W-1:0]      rsp_out_index,
   output logic                             rsp_last,
   input  logic                             csr_we,
   input  logic [rbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rbd_pkg::*;

   logic              queue_push;
   rbd_item_type      front_item;
   rbd_item_type      head_item;
   logic              queue_pop;
   logic              queue_empty;
   logic [QCNT_W-1:0] queue_count;

   rbd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .queue_count     (queue_count),
      .queue_push      (queue_push),
      .queue_item      (front_item)
   );

   rbd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (queue_push),
      .wr_item (front_item),
      .rd_en   (queue_pop),
      .rd_item (head_item),
      .empty   (queue_empty),
      .count   (queue_count)
   );

   rbd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_item    (head_item),
      .queue_empty   (queue_empty),
      .queue_pop     (queue_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_index (rsp_out_index),
      .rsp_last      (rsp_last)
   );

endmodule
